>>> rtl/core/bbb_pkg.sv
// ----------------------------------------------------------------------------
// bbb_pkg
// Shared sizes, codes and the controller command type for the bounded buffer.
// ----------------------------------------------------------------------------
package bbb_pkg;

  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 8;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int FILL_W     = 4;
  localparam int STATUS_W   = 2;

  localparam logic OP_PRODUCE = 1'b0;
  localparam logic OP_CONSUME = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WAITING = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

endpackage

>>> rtl/core/blocking_bounded_buffer.sv
// ----------------------------------------------------------------------------
// blocking_bounded_buffer
// Bounded buffer between one producer and one consumer with blocking flags.
//
//   channel   handshake           payload
//   in_       start / busy        in_op, in_value
//   out_      out_strobe          out_status, out_data_valid, out_data_out,
//                                 out_woke_partner, out_fill_level,
//                                 out_producer_waits, out_consumer_waits
//
// a beat is taken on start while busy is low; busy is high for one execute
// cycle, and the result strobes in the cycle after, so no new beat is taken
// while one is in execute; the pace is set by the controller's idle/execute states
// synchronous active-low reset clears positions and flags; slots are not cleared
// the receiver cannot stall: each result is shown for one cycle only
// ----------------------------------------------------------------------------
module blocking_bounded_buffer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_op,
  input  logic [bbb_pkg::DATA_WIDTH-1:0] in_value,
  output logic                           out_strobe,
  output logic [bbb_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_data_valid,
  output logic [bbb_pkg::DATA_WIDTH-1:0] out_data_out,
  output logic                           out_woke_partner,
  output logic [bbb_pkg::FILL_W-1:0]     out_fill_level,
  output logic                           out_producer_waits,
  output logic                           out_consumer_waits
);

  bbb_pkg::ctrl_cmd_t cmd;

  bbb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .out_strobe (out_strobe)
  );

  bbb_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_op              (in_op),
    .in_value           (in_value),
    .out_status         (out_status),
    .out_data_valid     (out_data_valid),
    .out_data_out       (out_data_out),
    .out_woke_partner   (out_woke_partner),
    .out_fill_level     (out_fill_level),
    .out_producer_waits (out_producer_waits),
    .out_consumer_waits (out_consumer_waits)
  );

endmodule

>>> rtl/core/bbb_ctrl.sv
// ----------------------------------------------------------------------------
// bbb_ctrl
// Command sequencer: takes a beat, runs its execute state, strobes the result.
// ----------------------------------------------------------------------------
module bbb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output bbb_pkg::ctrl_cmd_t cmd,
  output logic               out_strobe
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;
  logic strobe_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == S_EXEC);
    end
  end

  assign busy        = (state_r == S_EXEC);
  assign cmd.capture = start && (state_r == S_IDLE);
  assign cmd.exec    = (state_r == S_EXEC);
  assign out_strobe  = strobe_r;

endmodule

>>> rtl/core/bbb_datapath.sv
// ----------------------------------------------------------------------------
// bbb_datapath
// Slot storage, write/read positions, waiting flags and result registers.
// ----------------------------------------------------------------------------
module bbb_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bbb_pkg::ctrl_cmd_t                  cmd,
  input  logic                                in_op,
  input  logic [bbb_pkg::DATA_WIDTH-1:0]      in_value,
  output logic [bbb_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_data_valid,
  output logic [bbb_pkg::DATA_WIDTH-1:0]      out_data_out,
  output logic                                out_woke_partner,
  output logic [bbb_pkg::FILL_W-1:0]          out_fill_level,
  output logic                                out_producer_waits,
  output logic                                out_consumer_waits
);

  localparam logic [bbb_pkg::CNT_W-1:0] FULL_CNT = bbb_pkg::CNT_W'(bbb_pkg::DEPTH);
  localparam logic [bbb_pkg::CNT_W-1:0] ONE_CNT  = bbb_pkg::CNT_W'(1);

  logic [bbb_pkg::DATA_WIDTH-1:0] mem [bbb_pkg::DEPTH];
  logic [bbb_pkg::DATA_WIDTH-1:0] rd_data_r;

  logic [bbb_pkg::CNT_W-1:0]      wc_r, wc_nxt;
  logic [bbb_pkg::CNT_W-1:0]      ri_r, ri_nxt;
  logic                           pw_r, pw_nxt;
  logic                           cw_r, cw_nxt;
  logic [bbb_pkg::DATA_WIDTH-1:0] held_r, held_nxt;
  logic                           op_r;
  logic [bbb_pkg::DATA_WIDTH-1:0] val_r;

  logic [bbb_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic                           valid_r, valid_nxt;
  logic [bbb_pkg::DATA_WIDTH-1:0] data_r, data_nxt;
  logic                           woke_r, woke_nxt;
  logic [bbb_pkg::FILL_W-1:0]     fill_r;
  logic                           pw_out_r, cw_out_r;

  logic                           we;
  logic [bbb_pkg::PTR_W-1:0]      waddr;
  logic [bbb_pkg::DATA_WIDTH-1:0] wdata;
  logic [bbb_pkg::CNT_W-1:0]      wc_inc;
  logic [bbb_pkg::CNT_W-1:0]      ri_inc;

  assign wc_inc = wc_r + ONE_CNT;
  assign ri_inc = ri_r + ONE_CNT;

  always_comb begin
    wc_nxt     = wc_r;
    ri_nxt     = ri_r;
    pw_nxt     = pw_r;
    cw_nxt     = cw_r;
    held_nxt   = held_r;
    status_nxt = bbb_pkg::ST_DONE;
    valid_nxt  = 1'b0;
    data_nxt   = '0;
    woke_nxt   = 1'b0;
    we         = 1'b0;
    waddr      = wc_r[bbb_pkg::PTR_W-1:0];
    wdata      = val_r;
    if (op_r == bbb_pkg::OP_PRODUCE) begin
      priority if (pw_r) begin
        status_nxt = bbb_pkg::ST_REFUSED;
      end else if (wc_r >= FULL_CNT) begin
        held_nxt   = val_r;
        pw_nxt     = 1'b1;
        status_nxt = bbb_pkg::ST_WAITING;
      end else begin
        we     = 1'b1;
        wc_nxt = wc_inc;
        if (cw_r) begin
          cw_nxt   = 1'b0;
          woke_nxt = 1'b1;
          if (ri_r < wc_inc) begin
            valid_nxt = 1'b1;
            data_nxt  = (ri_r == wc_r) ? val_r : rd_data_r;
            if (ri_inc >= wc_inc) begin
              ri_nxt = '0;
              wc_nxt = '0;
            end else begin
              ri_nxt = ri_inc;
            end
          end
        end
      end
    end else begin
      priority if (cw_r) begin
        status_nxt = bbb_pkg::ST_REFUSED;
      end else if (ri_r >= wc_r) begin
        cw_nxt     = 1'b1;
        status_nxt = bbb_pkg::ST_WAITING;
      end else begin
        valid_nxt = 1'b1;
        data_nxt  = rd_data_r;
        if (ri_inc >= wc_r) begin
          ri_nxt = '0;
          wc_nxt = '0;
          if (pw_r) begin
            pw_nxt   = 1'b0;
            woke_nxt = 1'b1;
            we       = 1'b1;
            waddr    = '0;
            wdata    = held_r;
            wc_nxt   = ONE_CNT;
          end
        end else begin
          ri_nxt = ri_inc;
        end
      end
    end
  end

  // slot array: one write port, one registered read port at the read position
  always_ff @(posedge clk) begin
    if (cmd.exec && we) mem[waddr] <= wdata;
    rd_data_r <= mem[ri_r[bbb_pkg::PTR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r   <= '0;
      ri_r   <= '0;
      pw_r   <= 1'b0;
      cw_r   <= 1'b0;
      held_r <= '0;
    end else if (cmd.exec) begin
      wc_r   <= wc_nxt;
      ri_r   <= ri_nxt;
      pw_r   <= pw_nxt;
      cw_r   <= cw_nxt;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      val_r <= in_value;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      valid_r  <= valid_nxt;
      data_r   <= data_nxt;
      woke_r   <= woke_nxt;
      fill_r   <= bbb_pkg::FILL_W'(wc_nxt - ri_nxt);
      pw_out_r <= pw_nxt;
      cw_out_r <= cw_nxt;
    end
  end

  assign out_status         = status_r;
  assign out_data_valid     = valid_r;
  assign out_data_out       = data_r;
  assign out_woke_partner   = woke_r;
  assign out_fill_level     = fill_r;
  assign out_producer_waits = pw_out_r;
  assign out_consumer_waits = cw_out_r;

endmodule

>>> rtl/core/bbb_checker.sv
// ----------------------------------------------------------------------------
// bbb_checker
// Port-level checks on the bounded buffer, bound to the top level.
// ----------------------------------------------------------------------------
module bbb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_strobe,
  input logic [bbb_pkg::STATUS_W-1:0]   out_status,
  input logic                           out_data_valid,
  input logic [bbb_pkg::DATA_WIDTH-1:0] out_data_out,
  input logic                           out_woke_partner,
  input logic [bbb_pkg::FILL_W-1:0]     out_fill_level,
  input logic                           out_producer_waits,
  input logic                           out_consumer_waits
);

  // accepted beat yields a strobe once its execute cycle is over
  a_beat_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_strobe)
    else $error("accepted beat gave no result");

  // a strobe only follows an execute cycle
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a beat in flight");

  // refused call hands nothing over and wakes no one
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == bbb_pkg::ST_REFUSED |-> !out_data_valid && !out_woke_partner)
    else $error("refused call had side effects");

  // no data without a hand-over; both sides never wait together
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data_valid |-> out_data_out == '0)
    else $error("data shown without hand-over");

  a_wait_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_producer_waits && out_consumer_waits) &&
                   out_fill_level <= bbb_pkg::FILL_W'(bbb_pkg::DEPTH))
    else $error("waiting flags or fill level out of range");

endmodule

bind blocking_bounded_buffer bbb_checker u_bbb_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_strobe         (out_strobe),
  .out_status         (out_status),
  .out_data_valid     (out_data_valid),
  .out_data_out       (out_data_out),
  .out_woke_partner   (out_woke_partner),
  .out_fill_level     (out_fill_level),
  .out_producer_waits (out_producer_waits),
  .out_consumer_waits (out_consumer_waits)
);
